@@ hw/rtl/mds_pkg.sv @@
// Shared types and constants for the multi-dimensional index stepper.
package mds_pkg;

    localparam int DIGIT_W     = 17;
    localparam int EXTENT_W    = 16;
    localparam int NUM_EXT_REG = 4;
    localparam int NUM_OUT_DIG = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int DIMS_W      = 3;
    localparam int SEL_W       = 2;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 8;
    localparam int M_TDATA_W   = 72;
    localparam int M_TUSER_W   = 8;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_NEXT   = 2'd1,
        KIND_NONDEC = 2'd2,
        KIND_PREV   = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMS  = 3'd0,
        CFG_EXT_0 = 3'd1,
        CFG_EXT_1 = 3'd2,
        CFG_EXT_2 = 3'd3,
        CFG_EXT_3 = 3'd4
    } t_cfg_idx;

    typedef logic signed [DIGIT_W-1:0] t_digit;

    // Per-cell control for one item.
    typedef struct packed {
        t_kind kind;
        logic  active;   // cell is within the dimensions in use
        logic  last;     // fastest active dimension
        logic  load_en;  // this cell is the load target
    } t_cell_ctrl;

    typedef struct packed {
        logic                        stepped;
        logic                        in_range;
        logic [NUM_OUT_DIG-1:0][DIGIT_W-1:0] digits;
    } t_result;

endpackage

@@ hw/rtl/mds_cell.sv @@
// One digit cell: holds a digit, takes a carry from the faster neighbor, a fill from the slower.
module mds_cell
    import mds_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  t_cell_ctrl          i_ctrl,
    input  logic [EXTENT_W-1:0] i_extent,
    input  t_digit              i_load_value,
    input  logic                i_carry,      // all faster active digits are at their limit
    input  t_digit              i_fill,       // incremented value from a slower digit
    input  logic                i_end,        // carry ran out of the slowest digit
    output logic                o_carry,
    output t_digit              o_fill,
    output t_digit              o_next,
    output logic                o_range_ok
);

    t_digit             r_digit;
    t_digit             n_digit;
    logic signed [17:0] d18;
    logic signed [17:0] ext18;
    logic signed [17:0] lim18;
    logic               inc_ok;
    logic               dec_ok;
    logic               take;
    logic               is_step;
    t_digit             d_inc;
    t_digit             d_dec;
    t_digit             ext_m1;
    t_digit             ext17;

    always_comb begin
        d18     = {r_digit[DIGIT_W-1], r_digit};
        ext18   = $signed({2'b00, i_extent});
        lim18   = ext18 - 18'sd1;
        inc_ok  = d18 < lim18;
        dec_ok  = d18 >= 18'sd1;
        d_inc   = r_digit + 17'sd1;
        d_dec   = r_digit - 17'sd1;
        ext_m1  = lim18[DIGIT_W-1:0];
        ext17   = $signed({1'b0, i_extent});
        is_step = (i_ctrl.kind != KIND_LOAD);
        take    = (i_ctrl.kind == KIND_PREV) ? dec_ok : inc_ok;

        o_carry = i_ctrl.active ? (i_carry && !take) : i_carry;
        o_fill  = (i_ctrl.active && i_carry && take) ? d_inc : i_fill;

        n_digit = r_digit;
        if (i_ctrl.load_en) begin
            n_digit = i_load_value;
        end else if (is_step && i_ctrl.active) begin
            if (i_end) begin
                if (i_ctrl.kind == KIND_PREV) begin
                    n_digit = i_ctrl.last ? -17'sd1 : 17'sd0;
                end else begin
                    n_digit = i_ctrl.last ? ext17 : ext_m1;
                end
            end else if (i_carry && take) begin
                n_digit = (i_ctrl.kind == KIND_PREV) ? d_dec : d_inc;
            end else if (i_carry) begin
                case (i_ctrl.kind)
                    KIND_NONDEC: n_digit = i_fill;
                    KIND_PREV:   n_digit = ext_m1;
                    default:     n_digit = 17'sd0;
                endcase
            end
        end

        o_next = n_digit;
        if (i_ctrl.active) begin
            o_range_ok = !n_digit[DIGIT_W-1] && (n_digit[EXTENT_W-1:0] < i_extent);
        end else begin
            o_range_ok = (n_digit == 17'sd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= 17'sd0;
        end else if (i_accept) begin
            r_digit <= n_digit;
        end
    end

endmodule

@@ hw/rtl/mds_out_buf.sv @@
// Two-entry output buffer (main plus skid) between the cell row and the result stream.
module mds_out_buf
    import mds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_result
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop      = r_main_v && i_pop_ready;
    assign o_ready  = !r_skid_v;
    assign o_valid  = r_main_v;
    assign o_result = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (pop || !r_main_v) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop || !r_main_v) begin
            r_main <= r_skid_v ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

endmodule

@@ hw/rtl/multi_dim_index_stepper.sv @@
// Multi-dimensional index stepper: a row of digit cells with ripple carry and fill chains.
// Each result is registered in the output buffer (main or skid entry) before it is offered.
// One item per cycle while the skid entry is empty; the carry and fill chains are combinational.
// Two-entry output buffer keeps input flowing while a result waits.
// Reset (sync, active low): digits zero, dims_in_use 1, every extent 1, buffer empty.
module multi_dim_index_stepper
    import mds_pkg::*;
#(
    parameter int MAX_DIMS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // tdata: load_value[16:0], zero pad [23:17]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // tuser: kind[1:0], digit_select[3:2], zero pad [7:4]
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // tdata: digit_out_0[16:0], digit_out_1[33:17], digit_out_2[50:34],
    //        digit_out_3[67:51], zero pad [71:68]
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // tuser: stepped[0], in_range[1], zero pad [7:2]
    output logic [M_TUSER_W-1:0] o_m_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [EXTENT_W-1:0]  i_cfg_data
);

    localparam int Q_W = $clog2(MAX_DIMS + 1);

    logic [DIMS_W-1:0]   r_dims;
    logic [EXTENT_W-1:0] r_extent [NUM_EXT_REG];

    logic                accept;
    t_kind               kind;
    logic [SEL_W-1:0]    sel;
    t_digit              load_value;
    logic [Q_W-1:0]      q;
    logic                carry [MAX_DIMS+1];
    t_digit              fill  [MAX_DIMS+1];
    t_digit              next_digit [MAX_DIMS];
    logic [MAX_DIMS-1:0] range_ok;
    t_result             result;
    t_result             out_result;

    assign accept      = i_s_tvalid && o_s_tready;
    assign kind        = t_kind'(i_s_tuser[1:0]);
    assign sel         = i_s_tuser[2 +: SEL_W];
    assign load_value  = $signed(i_s_tdata[DIGIT_W-1:0]);
    assign o_cfg_ready = 1'b1;

    // dims_in_use above MAX_DIMS acts as MAX_DIMS
    always_comb begin
        if (int'(r_dims) > MAX_DIMS) begin
            q = Q_W'(MAX_DIMS);
        end else begin
            q = Q_W'(r_dims);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= DIMS_W'(1);
            for (int i = 0; i < NUM_EXT_REG; i++) begin
                r_extent[i] <= EXTENT_W'(1);
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DIMS:  r_dims      <= i_cfg_data[DIMS_W-1:0];
                CFG_EXT_0: r_extent[0] <= i_cfg_data;
                CFG_EXT_1: r_extent[1] <= i_cfg_data;
                CFG_EXT_2: r_extent[2] <= i_cfg_data;
                CFG_EXT_3: r_extent[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // carry enters at the fastest cell, fill enters at the slowest
    assign carry[MAX_DIMS] = 1'b1;
    assign fill[0]         = 17'sd0;

    generate
        for (genvar n = 0; n < MAX_DIMS; n++) begin : g_cell
            t_cell_ctrl          ctrl;
            logic [EXTENT_W-1:0] extent;

            assign ctrl.kind    = kind;
            assign ctrl.active  = (n < int'(q));
            assign ctrl.last    = ((n + 1) == int'(q));
            assign ctrl.load_en = (kind == KIND_LOAD) && (int'(sel) == n);

            if (n < NUM_EXT_REG) begin : g_ext
                assign extent = r_extent[n];
            end else begin : g_fixed
                assign extent = EXTENT_W'(1);
            end

            mds_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_accept     (accept),
                .i_ctrl       (ctrl),
                .i_extent     (extent),
                .i_load_value (load_value),
                .i_carry      (carry[n+1]),
                .i_fill       (fill[n]),
                .i_end        (carry[0]),
                .o_carry      (carry[n]),
                .o_fill       (fill[n+1]),
                .o_next       (next_digit[n]),
                .o_range_ok   (range_ok[n])
            );
        end

        for (genvar k = 0; k < NUM_OUT_DIG; k++) begin : g_out
            if (k < MAX_DIMS) begin : g_dig
                assign result.digits[k] = next_digit[k];
            end else begin : g_zero
                assign result.digits[k] = '0;
            end
        end
    endgenerate

    assign result.stepped  = (kind != KIND_LOAD) && (q != '0) && !carry[0];
    assign result.in_range = &range_ok;

    mds_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (result),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_result    (out_result)
    );

    assign o_m_tdata = {{(M_TDATA_W - NUM_OUT_DIG*DIGIT_W){1'b0}}, out_result.digits};
    assign o_m_tuser = {{(M_TUSER_W - 2){1'b0}}, out_result.in_range, out_result.stepped};

endmodule

@@ tb/tb_multi_dim_index_stepper.sv @@
// Testbench for the multi-dimensional index stepper: stream driver, result monitor, predictor.
`timescale 1ns / 1ps

module tb_multi_dim_index_stepper;
    import mds_pkg::*;

    typedef struct {
        t_kind      kind;
        logic [1:0] sel;
        int         val;
    } t_stim_item;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic [S_TUSER_W-1:0] i_s_tuser   = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [M_TUSER_W-1:0] o_m_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [EXTENT_W-1:0]  i_cfg_data  = '0;

    t_stim_item item_q[$];
    t_result    index_expect_q[$];
    int         err_count = 0;
    int         result_count = 0;

    // predictor state
    int idx_digit[4];
    int idx_extent[4];
    int idx_dims;

    // idle control
    bit tx_fast = 1'b0;
    bit rx_fast = 1'b0;
    bit rx_block = 1'b0;
    int tx_gap = 0;
    int rx_wait = 0;
    t_stim_item tx_next;
    t_result    rx_want;

    multi_dim_index_stepper i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_error(string msg);
        if (err_count < 100) $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic void set_end_mark(int q);
        for (int n = 0; n < q - 1; n++) idx_digit[n] = idx_extent[n] - 1;
        idx_digit[q-1] = idx_extent[q-1];
    endfunction

    // Applies one item to the predicted index vector and returns the expected result.
    function automatic t_result advance_index(t_kind kind, logic [1:0] sel, int val);
        t_result r;
        int      q;
        bit      done;
        r    = '0;
        done = 1'b0;
        q    = (idx_dims > 4) ? 4 : idx_dims;
        if (kind == KIND_LOAD) begin
            idx_digit[sel] = val;
        end else if (q > 0) begin
            case (kind)
                KIND_NEXT: begin
                    for (int n = q - 1; n >= 0 && !done; n--) begin
                        if (idx_digit[n] < idx_extent[n] - 1) begin
                            idx_digit[n]++;
                            done = 1'b1;
                        end else begin
                            idx_digit[n] = 0;
                        end
                    end
                    if (!done) set_end_mark(q);
                end
                KIND_NONDEC: begin
                    for (int n = q - 1; n >= 0 && !done; n--) begin
                        if (idx_digit[n] < idx_extent[n] - 1) begin
                            idx_digit[n]++;
                            for (int m = n + 1; m < q; m++) idx_digit[m] = idx_digit[n];
                            done = 1'b1;
                        end
                    end
                    if (!done) set_end_mark(q);
                end
                KIND_PREV: begin
                    for (int n = q - 1; n >= 0 && !done; n--) begin
                        if (idx_digit[n] >= 1) begin
                            idx_digit[n]--;
                            done = 1'b1;
                        end else begin
                            idx_digit[n] = idx_extent[n] - 1;
                        end
                    end
                    if (!done) begin
                        for (int n = 0; n < q - 1; n++) idx_digit[n] = 0;
                        idx_digit[q-1] = -1;
                    end
                end
                default: ;
            endcase
        end
        r.stepped  = done;
        r.in_range = 1'b1;
        for (int n = 0; n < 4; n++) begin
            if (n < q) begin
                if (idx_digit[n] < 0 || idx_digit[n] >= idx_extent[n]) r.in_range = 1'b0;
            end else if (idx_digit[n] != 0) begin
                r.in_range = 1'b0;
            end
            r.digits[n] = 17'(idx_digit[n]);
        end
        return r;
    endfunction

    // Driver: presents queued items, predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                index_expect_q.push_back(advance_index(t_kind'(i_s_tuser[1:0]),
                                                       i_s_tuser[3:2],
                                                       $signed(i_s_tdata[16:0])));
                tx_gap = tx_fast ? 0 : $urandom_range(0, 6);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (item_q.size() != 0) begin
                    tx_next = item_q.pop_front();
                    i_s_tuser  <= {4'd0, tx_next.sel, tx_next.kind};
                    i_s_tdata  <= {7'd0, 17'(tx_next.val)};
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results, compares against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                result_count++;
                if (index_expect_q.size() == 0) begin
                    report_error($sformatf("result %0d with nothing pending, tdata %h",
                                           result_count, o_m_tdata));
                end else begin
                    rx_want = index_expect_q.pop_front();
                    if (o_m_tuser[0] !== rx_want.stepped)
                        report_error($sformatf("result %0d stepped got %b want %b",
                                               result_count, o_m_tuser[0], rx_want.stepped));
                    if (o_m_tuser[1] !== rx_want.in_range)
                        report_error($sformatf("result %0d in_range got %b want %b",
                                               result_count, o_m_tuser[1], rx_want.in_range));
                    for (int k = 0; k < 4; k++) begin
                        if (o_m_tdata[17*k +: 17] !== rx_want.digits[k])
                            report_error($sformatf("result %0d digit %0d got %h want %h",
                                                   result_count, k, o_m_tdata[17*k +: 17],
                                                   rx_want.digits[k]));
                    end
                end
                rx_wait = rx_fast ? 0 : $urandom_range(0, 6);
            end
            if (rx_block) begin
                i_m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic void add_item(t_kind kind, logic [1:0] sel, int val);
        t_stim_item it;
        it.kind = kind;
        it.sel  = sel;
        it.val  = val;
        item_q.push_back(it);
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DIMS:  idx_dims      = int'(data[2:0]);
            CFG_EXT_0: idx_extent[0] = int'(data);
            CFG_EXT_1: idx_extent[1] = int'(data);
            CFG_EXT_2: idx_extent[2] = int'(data);
            CFG_EXT_3: idx_extent[3] = int'(data);
            default: ;
        endcase
    endtask

    // Sender has nothing left and every prediction has been matched.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (item_q.size() != 0 || i_s_tvalid || index_expect_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int         pick;
        int         dims_pick;
        int         ext_pick;
        t_stim_item it;

        idx_dims = 1;
        for (int n = 0; n < 4; n++) begin
            idx_digit[n]  = 0;
            idx_extent[n] = 1;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one dimension of extent one
        @(negedge i_clk);
        add_item(KIND_NEXT, 2'd0, 0);
        add_item(KIND_PREV, 2'd1, 65535);
        add_item(KIND_NONDEC, 2'd2, -1);
        add_item(KIND_LOAD, 2'd3, -1);
        add_item(KIND_NEXT, 2'd0, 0);
        add_item(KIND_LOAD, 2'd3, 0);
        wait_drained();

        // four dimensions at the extent extremes
        write_reg(CFG_DIMS, 16'd4);
        write_reg(CFG_EXT_0, 16'd65535);
        write_reg(CFG_EXT_1, 16'd2);
        write_reg(CFG_EXT_2, 16'd1);
        write_reg(CFG_EXT_3, 16'd65535);
        @(negedge i_clk);
        add_item(KIND_LOAD, 2'd0, 65534);
        add_item(KIND_LOAD, 2'd1, 1);
        add_item(KIND_LOAD, 2'd2, 0);
        add_item(KIND_LOAD, 2'd3, 65534);
        add_item(KIND_NEXT, 2'd0, 0);
        add_item(KIND_PREV, 2'd0, 0);
        add_item(KIND_NONDEC, 2'd0, 0);
        add_item(KIND_PREV, 2'd0, 0);
        add_item(KIND_LOAD, 2'd3, -1);
        add_item(KIND_PREV, 2'd0, 0);
        add_item(KIND_LOAD, 2'd0, 65535);
        wait_drained();

        // no dimensions in use; upper data bits of the dims write are don't-care
        write_reg(CFG_DIMS, 16'hFFF8);
        @(negedge i_clk);
        add_item(KIND_NEXT, 2'd0, 0);
        add_item(KIND_NONDEC, 2'd0, 0);
        add_item(KIND_PREV, 2'd0, 0);
        add_item(KIND_LOAD, 2'd1, 5);
        wait_drained();

        // dims beyond the vector size, and a zero extent
        write_reg(CFG_DIMS, 16'd7);
        write_reg(CFG_EXT_0, 16'd2);
        write_reg(CFG_EXT_1, 16'd3);
        write_reg(CFG_EXT_2, 16'd0);
        write_reg(CFG_EXT_3, 16'd2);
        @(negedge i_clk);
        add_item(KIND_NEXT, 2'd0, 0);
        add_item(KIND_PREV, 2'd0, 0);
        add_item(KIND_NONDEC, 2'd0, 0);
        add_item(KIND_LOAD, 2'd2, -1);

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            pick = $urandom_range(0, 9);
            dims_pick = (pick < 7) ? $urandom_range(1, 4) :
                        (pick == 7) ? 0 : $urandom_range(5, 7);
            write_reg(CFG_DIMS, 16'(dims_pick));
            for (int e = 0; e < 4; e++) begin
                pick = $urandom_range(0, 19);
                ext_pick = (pick < 14) ? $urandom_range(1, 4) :
                           (pick < 16) ? 65535 :
                           (pick < 19) ? $urandom_range(1, 65535) : 0;
                write_reg(t_cfg_idx'(CFG_EXT_0 + e), 16'(ext_pick));
            end
            @(negedge i_clk);
            tx_fast = (p % 3 == 0);
            rx_fast = (p % 3 == 1);
            for (int k = 0; k < 105; k++) begin
                pick = $urandom_range(0, 99);
                it.kind = (pick < 20) ? KIND_LOAD : (pick < 50) ? KIND_NEXT :
                          (pick < 75) ? KIND_NONDEC : KIND_PREV;
                it.sel = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 6))
                    0: it.val = -1;
                    1: it.val = 65535;
                    2: it.val = 65534;
                    3: it.val = $urandom_range(0, 65535);
                    default: it.val = $urandom_range(0, 4);
                endcase
                item_q.push_back(it);
            end
            if (p == 2) begin
                // receiver holds off while the sender keeps offering items
                tx_fast = 1'b1;
                fork
                    begin
                        @(posedge i_clk);
                        rx_block <= 1'b1;
                        repeat (150) @(posedge i_clk);
                        rx_block <= 1'b0;
                    end
                join_none
            end
        end

        wait_drained();
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(64'd8_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mds_pkg.sv
hw/rtl/mds_cell.sv
hw/rtl/mds_out_buf.sv
hw/rtl/multi_dim_index_stepper.sv
tb/tb_multi_dim_index_stepper.sv
